### design/mvt_pkg.sv
// Package for the 4x4 matrix-vector transform engine.
// Holds the word types, the operation codes and the pipeline enable struct.
// No dependencies.
package mvt_pkg;

   localparam int WORD_WIDTH  = 32;
   localparam int VEC_LEN     = 4;
   localparam int INDEX_WIDTH = 4;
   localparam int PROD_WIDTH  = 2 * WORD_WIDTH;
   // Four full products summed: two guard bits cover the growth.
   localparam int SUM_WIDTH   = PROD_WIDTH + 2;

   localparam logic OP_LOAD      = 1'b0;
   localparam logic OP_TRANSFORM = 1'b1;

   typedef logic signed [WORD_WIDTH-1:0]  word_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;
   typedef logic        [INDEX_WIDTH-1:0] index_type;

   typedef struct packed {
      logic prod_en;
      logic out_en;
   } stage_en_type;

endpackage

### design/mvt_row_unit.sv
// One matrix row of the transform: registered products, then sum, shift and saturate.
// Depends on mvt_pkg.
module mvt_row_unit #(
   parameter int DIMENSION     = 4,
   parameter int FRACTION_BITS = 16
) (
   input  logic                   clock,
   input  mvt_pkg::stage_en_type  stage_en,
   input  mvt_pkg::word_type      row_entry [mvt_pkg::VEC_LEN],
   input  mvt_pkg::word_type      vec       [mvt_pkg::VEC_LEN],
   output mvt_pkg::word_type      result
);
   import mvt_pkg::*;

   localparam sum_type SAT_MAX = sum_type'((SUM_WIDTH'(1) << (WORD_WIDTH - 1)) - SUM_WIDTH'(1));
   localparam sum_type SAT_MIN = -sum_type'(SUM_WIDTH'(1) << (WORD_WIDTH - 1));

   prod_type prod_in [VEC_LEN];
   prod_type prod_ff [VEC_LEN];
   sum_type  sum_in;
   sum_type  shifted;
   word_type result_in;
   word_type result_ff;

   for (genvar c = 0; c < VEC_LEN; c++) begin : g_col
      if (c < DIMENSION) begin : g_mul
         assign prod_in[c] = prod_type'(row_entry[c]) * prod_type'(vec[c]);
      end else begin : g_zero
         assign prod_in[c] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.prod_en) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      sum_in = sum_type'(prod_ff[0]) + sum_type'(prod_ff[1])
             + sum_type'(prod_ff[2]) + sum_type'(prod_ff[3]);
      // arithmetic shift rounds toward minus infinity
      shifted = sum_in >>> FRACTION_BITS;
      if (shifted > SAT_MAX) begin
         result_in = word_type'(SAT_MAX);
      end else if (shifted < SAT_MIN) begin
         result_in = word_type'(SAT_MIN);
      end else begin
         result_in = word_type'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.out_en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

### design/matrix_vector_transform_4x4.sv
// Top level of the matrix-vector transform engine: matrix registers, pipeline control.
// Depends on mvt_pkg and mvt_row_unit.
//
// Usage:
//   The req channel carries one word per accepted cycle (req_valid high, req_stall low).
//   A load word (operation 0) writes one signed Q16.16 element at row*4+column into
//   the matrix at the accepting edge and gives no result; an index outside the active
//   square is dropped. A transform word (operation 1) carries a vector and yields one
//   rsp word with the four saturated row dot products.
//   A transform passes through the input register, product register and result
//   register before rsp_valid shows it.
//   Throughput: one word per cycle while rsp_stall is low, set by the three-stage
//   pipeline that holds the sixteen 32x32 multipliers, one per matrix element.
//   Loads are taken at the same rate and never reorder against transforms: each
//   transform reads the matrix as it stood when it was accepted.
//   When the receiver raises rsp_stall the result holds, then the stages fill and
//   req_stall rises once all three are occupied.
//   Reset clears the matrix to zero and empties the pipeline.
module matrix_vector_transform_4x4 #(
   parameter int DIMENSION     = 4,
   parameter int FRACTION_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_operation,
   input  mvt_pkg::index_type  req_element_index,
   input  mvt_pkg::word_type   req_element_value,
   input  mvt_pkg::word_type   req_vec_x,
   input  mvt_pkg::word_type   req_vec_y,
   input  mvt_pkg::word_type   req_vec_z,
   input  mvt_pkg::word_type   req_vec_w,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mvt_pkg::word_type   rsp_out_x,
   output mvt_pkg::word_type   rsp_out_y,
   output mvt_pkg::word_type   rsp_out_z,
   output mvt_pkg::word_type   rsp_out_w
);
   import mvt_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic         prod_valid_ff, prod_valid_in;
   logic         out_valid_ff, out_valid_in;
   logic         out_ready, prod_ready, in_ready;
   logic         req_accept;
   logic         load_accept;
   stage_en_type stage_en;
   word_type     vec_in [VEC_LEN];
   word_type     vec_ff [VEC_LEN];
   word_type     entry_word [VEC_LEN][VEC_LEN];
   word_type     row_result [VEC_LEN];

   // Each stage advances when the one after it is empty or moving.
   assign out_ready  = !out_valid_ff || !rsp_stall;
   assign prod_ready = !prod_valid_ff || out_ready;
   assign in_ready   = !in_valid_ff || prod_ready;
   assign req_stall  = !in_ready;

   assign req_accept  = req_valid && in_ready;
   assign load_accept = req_accept && (req_operation == OP_LOAD);

   assign stage_en.prod_en = prod_ready;
   assign stage_en.out_en  = out_ready;

   always_comb begin
      in_valid_in   = in_ready   ? (req_accept && (req_operation == OP_TRANSFORM))
                                 : in_valid_ff;
      prod_valid_in = prod_ready ? in_valid_ff   : prod_valid_ff;
      out_valid_in  = out_ready  ? prod_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign vec_in[0] = req_vec_x;
   assign vec_in[1] = req_vec_y;
   assign vec_in[2] = req_vec_z;
   assign vec_in[3] = req_vec_w;

   always_ff @(posedge clock) begin
      if (in_ready) begin
         vec_ff <= vec_in;
      end
   end

   // Matrix elements outside the active square have no storage and read as zero.
   for (genvar r = 0; r < VEC_LEN; r++) begin : g_row
      for (genvar c = 0; c < VEC_LEN; c++) begin : g_col
         if (r < DIMENSION && c < DIMENSION) begin : g_entry
            word_type entry_ff;
            logic     hit;
            assign hit = load_accept
                      && (req_element_index == INDEX_WIDTH'(r * VEC_LEN + c));
            always_ff @(posedge clock) begin
               if (reset) begin
                  entry_ff <= '0;
               end else if (hit) begin
                  entry_ff <= req_element_value;
               end
            end
            assign entry_word[r][c] = entry_ff;
         end else begin : g_empty
            assign entry_word[r][c] = '0;
         end
      end

      if (r < DIMENSION) begin : g_unit
         mvt_row_unit #(
            .DIMENSION     (DIMENSION),
            .FRACTION_BITS (FRACTION_BITS)
         ) u_row (
            .clock     (clock),
            .stage_en  (stage_en),
            .row_entry (entry_word[r]),
            .vec       (vec_ff),
            .result    (row_result[r])
         );
      end else begin : g_unused
         assign row_result[r] = '0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_out_x = row_result[0];
   assign rsp_out_y = row_result[1];
   assign rsp_out_z = row_result[2];
   assign rsp_out_w = row_result[3];

endmodule
